>>> src/datediff_pkg.sv
package datediff_pkg;

   localparam int YEAR_W   = 14;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int ERR_W    = 2;
   localparam int DUR_W    = 23;
   localparam int DCOUNT_W = 22;
   localparam int QUOT_W   = 8;
   localparam int LEAPD_W  = 12;
   localparam int MDAYS_W  = 9;

   localparam int YEAR_MIN      = 1900;
   localparam int YEAR_MAX      = 9999;
   localparam int MONTH_MAX     = 12;
   localparam int MONTH_FEB     = 2;
   localparam int DAYS_PER_YEAR = 365;
   localparam int CENTURY       = 100;

   // floor(x / 100) = (x * 5243) >> 19 for every 14-bit x
   localparam int RECIP_100   = 5243;
   localparam int RECIP_SHIFT = 19;
   localparam int RECIP_W     = 13;
   localparam int PROD_W      = YEAR_W + RECIP_W;

   // leap years in 1..1899
   localparam int LEAPS_BEFORE_MIN = (YEAR_MIN - 1) / 4 - (YEAR_MIN - 1) / 100
                                     + (YEAR_MIN - 1) / 400;

   typedef enum logic [ERR_W-1:0] {
      ERR_NONE  = 2'd0,
      ERR_START = 2'd1,
      ERR_END   = 2'd2
   } err_code_type;

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
   } stage_en_type;

   function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m,
                                                     input logic leap);
      logic [DAY_W-1:0] len;
      case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         4'd2:                                       len = leap ? 5'd29 : 5'd28;
         default:                                    len = 5'd0;
      endcase
      return len;
   endfunction

   function automatic logic [MDAYS_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
      logic [MDAYS_W-1:0] n;
      case (m)
         4'd2:    n = 9'd31;
         4'd3:    n = 9'd59;
         4'd4:    n = 9'd90;
         4'd5:    n = 9'd120;
         4'd6:    n = 9'd151;
         4'd7:    n = 9'd181;
         4'd8:    n = 9'd212;
         4'd9:    n = 9'd243;
         4'd10:   n = 9'd273;
         4'd11:   n = 9'd304;
         4'd12:   n = 9'd334;
         default: n = 9'd0;
      endcase
      return n;
   endfunction

endpackage

>>> src/datediff_if.sv
interface datediff_req_if;
   logic                                valid;
   logic                                ready;
   logic [datediff_pkg::YEAR_W-1:0]     start_year;
   logic [datediff_pkg::MONTH_W-1:0]    start_month;
   logic [datediff_pkg::DAY_W-1:0]      start_day;
   logic [datediff_pkg::YEAR_W-1:0]     end_year;
   logic [datediff_pkg::MONTH_W-1:0]    end_month;
   logic [datediff_pkg::DAY_W-1:0]      end_day;

   modport source (output valid, start_year, start_month, start_day,
                          end_year, end_month, end_day,
                   input  ready);
   modport sink   (input  valid, start_year, start_month, start_day,
                          end_year, end_month, end_day,
                   output ready);
endinterface

interface datediff_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [datediff_pkg::ERR_W-1:0]      error_code;
   logic signed [datediff_pkg::DUR_W-1:0] duration_days;

   modport source (output valid, error_code, duration_days, input ready);
   modport sink   (input  valid, error_code, duration_days, output ready);
endinterface

>>> src/date_difference_in_days.sv
// Throughput: one item per cycle while the output side is ready; three lane stages and
// the merge register run as a pipeline, each stage moving up whenever the stage after it
// is empty or moving.
// Reset (synchronous, active high) clears every stage valid flag; the data
// registers are not reset.
module date_difference_in_days (
   input  logic          clock,
   input  logic          reset,
   datediff_req_if.sink   req_if,
   datediff_rsp_if.source rsp_if
);
   import datediff_pkg::*;

   logic         v1_ff, v1_in;
   logic         v2_ff, v2_in;
   logic         v3_ff, v3_in;
   logic         v4_ff, v4_in;
   logic         en1, en2, en3, en4;
   stage_en_type lane_en;

   logic [DCOUNT_W-1:0] start_count, end_count;
   logic                start_ok, end_ok;
   err_code_type        err;

   // a stage advances when the next one is empty or advancing
   assign en4 = !v4_ff || rsp_if.ready;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;

   assign lane_en = '{s1: en1, s2: en2, s3: en3};

   assign v1_in = en1 ? req_if.valid : v1_ff;
   assign v2_in = en2 ? v1_ff : v2_ff;
   assign v3_in = en3 ? v2_ff : v3_ff;
   assign v4_in = en4 ? v3_ff : v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   datediff_lane u_start_lane (
      .clock     (clock),
      .en        (lane_en),
      .year      (req_if.start_year),
      .month     (req_if.start_month),
      .day       (req_if.start_day),
      .day_count (start_count),
      .date_ok   (start_ok)
   );

   datediff_lane u_end_lane (
      .clock     (clock),
      .en        (lane_en),
      .year      (req_if.end_year),
      .month     (req_if.end_month),
      .day       (req_if.end_day),
      .day_count (end_count),
      .date_ok   (end_ok)
   );

   datediff_merge u_merge (
      .clock         (clock),
      .load          (en4),
      .start_count   (start_count),
      .start_ok      (start_ok),
      .end_count     (end_count),
      .end_ok        (end_ok),
      .error_code    (err),
      .duration_days (rsp_if.duration_days)
   );

   assign req_if.ready      = en1;
   assign rsp_if.valid      = v4_ff;
   assign rsp_if.error_code = err;

endmodule

>>> src/datediff_lane.sv
module datediff_lane (
   input  logic                                 clock,
   input  datediff_pkg::stage_en_type           en,
   input  logic [datediff_pkg::YEAR_W-1:0]      year,
   input  logic [datediff_pkg::MONTH_W-1:0]     month,
   input  logic [datediff_pkg::DAY_W-1:0]       day,
   output logic [datediff_pkg::DCOUNT_W-1:0]    day_count,
   output logic                                 date_ok
);
   import datediff_pkg::*;

   // stage 1: quotients by 100 of year and year - 1
   logic [YEAR_W-1:0]   year_ff, year_in;
   logic [MONTH_W-1:0]  month1_ff;
   logic [DAY_W-1:0]    day1_ff;
   logic [QUOT_W-1:0]   q_ff, q_in;
   logic [QUOT_W-1:0]   qm1_ff, qm1_in;
   logic [YEAR_W-1:0]   year_m1;
   logic [PROD_W-1:0]   prod_y, prod_ym1;

   assign year_m1  = year - YEAR_W'(1);
   assign prod_y   = PROD_W'(year) * PROD_W'(RECIP_100);
   assign prod_ym1 = PROD_W'(year_m1) * PROD_W'(RECIP_100);
   assign year_in  = year;
   assign q_in     = prod_y[RECIP_SHIFT +: QUOT_W];
   assign qm1_in   = prod_ym1[RECIP_SHIFT +: QUOT_W];

   always_ff @(posedge clock) begin
      if (en.s1) begin
         year_ff   <= year_in;
         month1_ff <= month;
         day1_ff   <= day;
         q_ff      <= q_in;
         qm1_ff    <= qm1_in;
      end
   end

   // stage 2: leap test, validity and the partial counts
   logic [DCOUNT_W-1:0] base_ff, base_in;
   logic [LEAPD_W-1:0]  leapd_ff, leapd_in;
   logic [MDAYS_W-1:0]  mdays_ff, mdays_in;
   logic [DAY_W-1:0]    day2_ff;
   logic                ok2_ff, ok2_in;
   logic [YEAR_W-1:0]   rem100;
   logic [YEAR_W-1:0]   years_off;
   logic [YEAR_W-1:0]   year_ff_m1;
   logic                leap;
   logic [DAY_W-1:0]    mlen;
   logic                year_ok, month_ok, day_ok;

   always_comb begin
      rem100     = year_ff - YEAR_W'(q_ff) * YEAR_W'(CENTURY);
      leap       = (year_ff[1:0] == 2'b00) && ((rem100 != '0) || (q_ff[1:0] == 2'b00));
      years_off  = year_ff - YEAR_W'(YEAR_MIN);
      year_ff_m1 = year_ff - YEAR_W'(1);
      base_in    = DCOUNT_W'(years_off) * DCOUNT_W'(DAYS_PER_YEAR);
      leapd_in   = LEAPD_W'(year_ff_m1 >> 2) - LEAPD_W'(qm1_ff) + LEAPD_W'(qm1_ff >> 2)
                   - LEAPD_W'(LEAPS_BEFORE_MIN);
      mdays_in   = days_before_month(month1_ff)
                   + MDAYS_W'((month1_ff > MONTH_W'(MONTH_FEB)) && leap);
      mlen       = month_length(month1_ff, leap);
      year_ok    = year_ff inside {[YEAR_W'(YEAR_MIN):YEAR_W'(YEAR_MAX)]};
      month_ok   = month1_ff inside {[MONTH_W'(1):MONTH_W'(MONTH_MAX)]};
      day_ok     = (day1_ff != '0) && (day1_ff <= mlen);
      ok2_in     = year_ok && month_ok && day_ok;
   end

   always_ff @(posedge clock) begin
      if (en.s2) begin
         base_ff  <= base_in;
         leapd_ff <= leapd_in;
         mdays_ff <= mdays_in;
         day2_ff  <= day1_ff;
         ok2_ff   <= ok2_in;
      end
   end

   // stage 3: sum into the day count
   logic [DCOUNT_W-1:0] count_ff, count_in;
   logic                ok3_ff;

   assign count_in = base_ff + DCOUNT_W'(leapd_ff) + DCOUNT_W'(mdays_ff) + DCOUNT_W'(day2_ff);

   always_ff @(posedge clock) begin
      if (en.s3) begin
         count_ff <= count_in;
         ok3_ff   <= ok2_ff;
      end
   end

   assign day_count = count_ff;
   assign date_ok   = ok3_ff;

endmodule

>>> src/datediff_merge.sv
module datediff_merge (
   input  logic                                   clock,
   input  logic                                   load,
   input  logic [datediff_pkg::DCOUNT_W-1:0]      start_count,
   input  logic                                   start_ok,
   input  logic [datediff_pkg::DCOUNT_W-1:0]      end_count,
   input  logic                                   end_ok,
   output datediff_pkg::err_code_type             error_code,
   output logic signed [datediff_pkg::DUR_W-1:0]  duration_days
);
   import datediff_pkg::*;

   err_code_type            err_ff, err_in;
   logic signed [DUR_W-1:0] dur_ff, dur_in;

   always_comb begin
      // start date is checked first; duration drops to zero on any error
      if (!start_ok) begin
         err_in = ERR_START;
         dur_in = '0;
      end else if (!end_ok) begin
         err_in = ERR_END;
         dur_in = '0;
      end else begin
         err_in = ERR_NONE;
         dur_in = $signed(DUR_W'(end_count) - DUR_W'(start_count));
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         err_ff <= err_in;
         dur_ff <= dur_in;
      end
   end

   assign error_code    = err_ff;
   assign duration_days = dur_ff;

endmodule

>>> src/datediff_checker.sv
module datediff_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   rsp_valid,
   input logic                                   rsp_ready,
   input logic [datediff_pkg::ERR_W-1:0]         rsp_error_code,
   input logic signed [datediff_pkg::DUR_W-1:0]  rsp_duration_days
);
   import datediff_pkg::*;

   localparam int DUR_LIMIT = 2958463;

   // a stalled result holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_error_code)
                                  && $stable(rsp_duration_days))
      else $error("stalled result changed");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_error_code == ERR_NONE) || (rsp_error_code == ERR_START)
                    || (rsp_error_code == ERR_END))
      else $error("undefined error code");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_error_code != ERR_NONE) |-> rsp_duration_days == '0)
      else $error("nonzero duration on error");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_error_code == ERR_NONE)
      |-> (rsp_duration_days <= DUR_W'(DUR_LIMIT))
          && (rsp_duration_days >= -DUR_W'(DUR_LIMIT)))
      else $error("duration out of range");

endmodule

bind date_difference_in_days datediff_checker u_datediff_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_if.valid),
   .rsp_ready         (rsp_if.ready),
   .rsp_error_code    (rsp_if.error_code),
   .rsp_duration_days (rsp_if.duration_days)
);
